// ===== hdl/mwacrc_pkg.sv =====
// Package: width codes, polynomials and bitwise CRC step functions for the multi-width CRC.
package mwacrc_pkg;

	localparam int unsigned CRC_W = 32;

	typedef logic [CRC_W-1:0] crc_t;
	typedef logic [1:0]       width_mode_t;

	localparam width_mode_t WM_8  = 2'd0;
	localparam width_mode_t WM_16 = 2'd1;
	localparam width_mode_t WM_32 = 2'd2;

	localparam crc_t POLY8  = 32'h0000_0007;
	localparam crc_t POLY16 = 32'h0000_1021;
	localparam crc_t POLY32 = 32'h04C1_1DB7;

	function automatic crc_t crc_mask(input width_mode_t mode);
		crc_t m;
		unique case (mode)
			WM_8:    m = 32'h0000_00FF;
			WM_16:   m = 32'h0000_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	// shift one bit in at the low end, fold in the polynomial on a carry out
	function automatic crc_t crc_bit(input crc_t r, input logic b, input width_mode_t mode);
		crc_t n;
		unique case (mode)
			WM_8:    n = {24'd0, r[6:0], b}  ^ (r[7]  ? POLY8  : '0);
			WM_16:   n = {16'd0, r[14:0], b} ^ (r[15] ? POLY16 : '0);
			default: n = {r[30:0], b}        ^ (r[31] ? POLY32 : '0);
		endcase
		return n;
	endfunction

	function automatic crc_t crc_byte(input crc_t r, input logic [7:0] d,
			input width_mode_t mode);
		crc_t acc;
		acc = r & crc_mask(mode);
		for (int i = 7; i >= 0; i--) begin
			acc = crc_bit(acc, d[i], mode);
		end
		return acc;
	endfunction

	function automatic crc_t crc_finish(input crc_t r, input crc_t e, input width_mode_t mode);
		crc_t acc;
		crc_t ev;
		acc = r & crc_mask(mode);
		ev  = e & crc_mask(mode);
		unique case (mode)
			WM_8: begin
				for (int i = 7; i >= 0; i--) acc = crc_bit(acc, ev[i], mode);
			end
			WM_16: begin
				for (int i = 15; i >= 0; i--) acc = crc_bit(acc, ev[i], mode);
			end
			default: begin
				for (int i = 31; i >= 0; i--) acc = crc_bit(acc, ev[i], mode);
			end
		endcase
		return acc;
	endfunction

endpackage

// ===== hdl/mwacrc_if.sv =====
// Interfaces: item channel and result channel of the multi-width CRC.
interface mwacrc_item_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  message_byte;
	logic [31:0] end_value;

	modport source(output valid, action, message_byte, end_value, input ready);
	modport sink(input valid, action, message_byte, end_value, output ready);
endinterface

interface mwacrc_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] crc_value;

	modport source(output valid, crc_value, input ready);
	modport sink(input valid, crc_value, output ready);
endinterface

// ===== hdl/multi_width_augmented_crc.sv =====
// Top level: multi-width augmented MSB-first CRC with item and result channels.
//
// Usage:
//   item channel: action 0 transfers one message byte, action 1 transfers the end
//   word (low 8, 16 or 32 bits used) and finishes the CRC.
//   result channel: one transfer of crc_value per end item, upper bits zero for
//   the narrow widths.
//   cfg_we / cfg_wdata write width_mode (0 = 8, 1 = 16, 2 or 3 = 32 bits); write
//   only while the block is idle.
// Timing:
//   An item is registered at its transfer and folded into the running CRC at the
//   next edge unless an end item waits for a pending result to be taken, one byte
//   or one end word per cycle through unrolled shift-XOR logic.
//   Throughput is one item per cycle as long as results are taken.
// Reset:
//   arst_n clears the input stage valid, the result valid flag and the running CRC, and
//   sets width_mode to 32 bits.
// Stall:
//   While a result waits, message bytes still advance; an end item holds in the
//   input stage and item.ready drops until the result is taken.
module multi_width_augmented_crc (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  mwacrc_pkg::width_mode_t   cfg_wdata,
	mwacrc_item_if.sink               item,
	mwacrc_result_if.source           result
);
	import mwacrc_pkg::*;

	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  byte_s1;
	crc_t        end_s1;

	width_mode_t width_mode_q;
	crc_t        crc_q;
	logic        res_valid_q;
	crc_t        res_crc_q;

	logic        go_s1;
	crc_t        msg_crc;
	crc_t        end_crc;

	assign go_s1      = valid_s1 && (!action_s1 || !res_valid_q || result.ready);
	assign item.ready = !valid_s1 || go_s1;

	assign msg_crc = crc_byte(crc_q, byte_s1, width_mode_q);
	assign end_crc = crc_finish(crc_q, end_s1, width_mode_q);

	assign result.valid     = res_valid_q;
	assign result.crc_value = res_crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_mode_q <= WM_32;
		end else if (cfg_we) begin
			width_mode_q <= cfg_wdata;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			action_s1 <= item.action;
			byte_s1   <= item.message_byte;
			end_s1    <= item.end_value;
		end
	end

	// running CRC and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '0;
			res_valid_q <= 1'b0;
		end else if (go_s1) begin
			if (action_s1) begin
				crc_q       <= '0;
				res_valid_q <= 1'b1;
			end else begin
				crc_q <= msg_crc;
				if (result.ready) begin
					res_valid_q <= 1'b0;
				end
			end
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && action_s1) begin
			res_crc_q <= end_crc;
		end
	end

endmodule

// ===== hdl/mwacrc_check.sv =====
// Checker: port-level assertions for the multi-width CRC, bound to the top level.
module mwacrc_check (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        item_action,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] crc_value
);

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(crc_value))
		else $error("stalled result changed");

	// an end transfer is followed by a valid result
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_action |-> ##2 result_valid)
		else $error("end transfer gave no result");

	// with no pending result the item channel is open
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item channel blocked without pending result");

	// reset drops any result
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result valid right after reset");

endmodule

bind multi_width_augmented_crc mwacrc_check u_mwacrc_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_action  (item.action),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.crc_value    (result.crc_value)
);

// ===== test/multi_width_augmented_crc_chk.sv =====
// Checker: watches the item and result channels, predicts each CRC and compares it.
module multi_width_augmented_crc_chk
	import mwacrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  width_mode_t cfg_wdata,
	mwacrc_item_if      item,
	mwacrc_result_if    result,
	output int          errors,
	output int          pending
);

	crc_t        crc_acc;
	width_mode_t width_sel;
	crc_t        crc_expected_q[$];

	function automatic int crc_bits(input width_mode_t mode);
		case (mode)
			WM_8:    return 8;
			WM_16:   return 16;
			default: return 32;
		endcase
	endfunction

	function automatic crc_t crc_shift_in(input crc_t acc, input crc_t bits, input int nbits,
			input width_mode_t mode);
		int   w;
		crc_t msk;
		crc_t poly;
		crc_t r;
		logic carry;
		w = crc_bits(mode);
		case (mode)
			WM_8:    poly = POLY8;
			WM_16:   poly = POLY16;
			default: poly = POLY32;
		endcase
		msk = (w == 32) ? '1 : ((crc_t'(1) << w) - crc_t'(1));
		r = acc & msk;
		for (int i = nbits - 1; i >= 0; i--) begin
			carry = r[w-1];
			r = ((r << 1) | crc_t'(bits[i])) & msk;
			if (carry)
				r = r ^ poly;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		crc_t want;
		if (!arst_n) begin
			crc_acc = '0;
			width_sel = WM_32;
			crc_expected_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (crc_expected_q.size() == 0) begin
					errors++;
					$display("%0t: crc_value expected none actual %h", $time, result.crc_value);
				end else begin
					want = crc_expected_q.pop_front();
					if (result.crc_value !== want) begin
						errors++;
						$display("%0t: crc_value expected %h actual %h", $time, want,
							result.crc_value);
					end
				end
			end
			if (item.valid && item.ready) begin
				if (item.action == 1'b0) begin
					crc_acc = crc_shift_in(crc_acc, {24'd0, item.message_byte}, 8, width_sel);
				end else begin
					crc_expected_q.push_back(crc_shift_in(crc_acc, item.end_value,
						crc_bits(width_sel), width_sel));
					crc_acc = '0;
				end
			end
			if (cfg_we)
				width_sel = cfg_wdata;
			pending = crc_expected_q.size();
		end
	end

endmodule

// ===== test/multi_width_augmented_crc_tb.sv =====
// Testbench top: clock, reset, stimulus for the multi-width CRC and the final verdict.
module multi_width_augmented_crc_tb;
	import mwacrc_pkg::*;

	localparam width_mode_t WM_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	width_mode_t cfg_wdata;
	int          errors;
	int          pending;
	int          hold_left;
	bit          idle_on;

	mwacrc_item_if   item_ch();
	mwacrc_result_if result_ch();

	multi_width_augmented_crc uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	multi_width_augmented_crc_chk chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stalls, long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready = 1'b0;
			end else begin
				result_ch.ready = !idle_on || ($urandom_range(99) >= 28);
			end
		end
	end

	task automatic xfer_item(input logic act, input logic [7:0] b, input logic [31:0] e);
		while (idle_on && $urandom_range(99) < 28) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.action = act;
		item_ch.message_byte = b;
		item_ch.end_value = e;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic set_width(input width_mode_t m);
		item_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		width_mode_t modes[4];
		int n;
		int sent;
		modes = '{WM_8, WM_16, WM_32, WM_UNUSED};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = WM_32;
		item_ch.valid = 1'b0;
		item_ch.action = 1'b0;
		item_ch.message_byte = '0;
		item_ch.end_value = '0;
		hold_left = 0;
		idle_on = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		xfer_item(1'b1, 8'h00, 32'h0000_0000);
		xfer_item(1'b0, 8'h00, 32'hFFFF_FFFF);
		xfer_item(1'b0, 8'hFF, 32'h0000_0000);
		xfer_item(1'b0, 8'h80, 32'h0000_0000);
		xfer_item(1'b0, 8'h01, 32'h0000_0000);
		xfer_item(1'b1, 8'hFF, 32'hFFFF_FFFF);
		xfer_item(1'b1, 8'h00, 32'h8000_0000);
		set_width(WM_8);
		xfer_item(1'b0, 8'hFF, 32'h0000_0000);
		xfer_item(1'b1, 8'hAA, 32'hFFFF_FF00);
		xfer_item(1'b0, 8'h5A, 32'h0000_0000);
		xfer_item(1'b1, 8'h00, 32'h0000_00FF);
		set_width(WM_16);
		xfer_item(1'b0, 8'hFF, 32'h0000_0000);
		xfer_item(1'b0, 8'h00, 32'h0000_0000);
		xfer_item(1'b1, 8'h00, 32'h0000_FFFF);
		xfer_item(1'b0, 8'h12, 32'h0000_0000);
		xfer_item(1'b1, 8'h00, 32'hABCD_0000);
		set_width(WM_UNUSED);
		xfer_item(1'b0, 8'hC3, 32'h0000_0000);
		xfer_item(1'b1, 8'h00, 32'hDEAD_BEEF);
		set_width(WM_32);
		xfer_item(1'b0, 8'hA5, 32'h0000_0000);
		xfer_item(1'b0, 8'h3C, 32'h0000_0000);
		set_width(WM_8);
		xfer_item(1'b0, 8'h7E, 32'h0000_0000);
		set_width(WM_16);
		xfer_item(1'b0, 8'h81, 32'h0000_0000);
		xfer_item(1'b1, 8'h00, 32'h1234_5678);

		for (int ph = 0; ph < 16; ph++) begin
			set_width(ph < 4 ? modes[ph] : modes[$urandom_range(3)]);
			idle_on = (ph != 5);
			if (ph == 9)
				hold_left = 400;
			sent = 0;
			while (sent < 125) begin
				n = $urandom_range(6);
				if ($urandom_range(9) == 0)
					n = $urandom_range(40, 20);
				for (int i = 0; i < n; i++)
					xfer_item(1'b0, 8'($urandom), $urandom);
				xfer_item(1'b1, 8'($urandom), $urandom);
				sent += n + 1;
			end
		end
		idle_on = 1'b1;

		item_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
